### src/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// Types and constants shared by the error-diffusion dither and its channels.
// ----------------------------------------------------------------------------
package edd_pkg;

  // Configuration register indexes
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  localparam logic [9:0] LINE_WIDTH_RESET = 10'd512;
  localparam logic [7:0] THRESHOLD_RESET  = 8'd128;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic dot;
    logic row_end;
  } dot_t;

  typedef struct packed {
    logic       index;
    logic [9:0] value;
  } cfg_t;

endpackage

### src/edd_stream_if.sv
// ----------------------------------------------------------------------------
// edd_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface edd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/error_diffusion_dither.sv
// Pipeline: an accepted pixel enters the compute stage, then its dot beat is
//   registered on the output (one compute stage plus the output register).
// Throughput: one pixel per clock while dots.ready holds, set by the single read
//   and single write port of the error line memory; the last column's write waits.
// Reset: clears all control state and the diffusion registers; the line memory
//   is not swept, a fill count marks which entries hold this frame's data.
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg dither: 8-bit gray pixels in raster order, one dot bit out.
// ----------------------------------------------------------------------------
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 512
) (
  input  logic         clk,
  input  logic         rst,
  edd_stream_if.sink   pix,
  edd_stream_if.source dots,
  edd_stream_if.sink   cfg
);
  import edd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column / address width
  localparam int FW = $clog2(MAX_WIDTH + 1);   // fill count width
  localparam int XW = (FW > 10) ? FW : 10;     // width compare

  // 12-bit saturation of a 13-bit signed sum
  function automatic logic signed [11:0] sat12(input logic signed [12:0] v);
    logic signed [11:0] r;
    if (v > 13'sd2047) r = 12'sh7ff;
    else if (v < -13'sd2048) r = 12'sh800;
    else r = v[11:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers; the port never stalls
  // --------------------------------------------------------------------------
  logic [9:0] line_width;
  logic [7:0] threshold;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      threshold  <= THRESHOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_LINE_WIDTH: line_width <= cfg.data.value;
        REG_THRESHOLD:  threshold  <= cfg.data.value[7:0];
        default: ;
      endcase
    end
  end

  // Effective width clamped to 2..MAX_WIDTH
  logic [XW-1:0] lw_ext;
  logic [XW-1:0] w_eff;

  always_comb begin
    lw_ext = XW'(line_width);
    if (lw_ext < XW'(2)) w_eff = XW'(2);
    else if (lw_ext > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = lw_ext;
  end

  // --------------------------------------------------------------------------
  // Handshake control: accept stage -> compute stage -> output register
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic in_acc;
  logic out_valid;

  assign s1_adv    = s1_valid && (!out_valid || dots.ready);
  assign pix.ready = !s1_valid || s1_adv;
  assign in_acc    = pix.valid && pix.ready;

  // --------------------------------------------------------------------------
  // Accept stage: column tracking and line memory read issue
  // --------------------------------------------------------------------------
  logic [CW-1:0] column_count;
  logic [CW-1:0] column_next;
  logic [CW-1:0] col_rd;
  logic          last_rd;

  always_comb begin
    col_rd      = pix.data.frame_start ? '0 : column_count;
    last_rd     = XW'(col_rd) >= (w_eff - XW'(1));
    column_next = last_rd ? '0 : col_rd + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) column_count <= '0;
    else if (in_acc) column_count <= column_next;
  end

  // Memory write port (driven from the compute stage and the deferred write)
  logic              s1_wr;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [11:0]       wr_data;
  logic [CW-1:0]     s1_col;
  logic signed [11:0] left_wr;       // lower-left value from compute stage
  logic              pw_valid;       // deferred write of the last column
  logic [CW-1:0]     pw_addr;
  logic [11:0]       pw_data;

  assign s1_wr   = s1_adv && (s1_col != '0);
  assign wr_en   = s1_wr || pw_valid;
  assign wr_addr = s1_wr ? s1_col - 1'b1 : pw_addr;
  assign wr_data = s1_wr ? left_wr : pw_data;

  // Entries below the fill count were written in the current frame
  logic [FW-1:0] fill;
  logic          rd_hit;

  assign rd_hit = wr_en && (wr_addr == col_rd);

  always_ff @(posedge clk) begin
    if (rst) fill <= '0;
    else if (in_acc && pix.data.frame_start) fill <= '0;
    else if (wr_en && (FW'(wr_addr) >= fill)) fill <= FW'(wr_addr) + 1'b1;
  end

  // Line memory, one read and one write a cycle
  logic [11:0] line_mem [MAX_WIDTH];
  logic [11:0] mem_q;

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr] <= wr_data;
    if (in_acc) mem_q <= line_mem[col_rd];
  end

  // Compute stage registers
  logic [7:0]  s1_pixel;
  logic        s1_fs;
  logic        s1_last;
  logic        s1_zero;       // entry stale or frame start: reads zero
  logic        s1_fwd;        // same-edge write forwarded
  logic [11:0] s1_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_acc) s1_valid <= 1'b1;
    else if (s1_adv) s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel    <= pix.data.pixel;
      s1_fs       <= pix.data.frame_start;
      s1_col      <= col_rd;
      s1_last     <= last_rd;
      s1_zero     <= pix.data.frame_start || (!rd_hit && (FW'(col_rd) >= fill));
      s1_fwd      <= rd_hit;
      s1_fwd_data <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage: correction, clip, quantize, diffuse
  // --------------------------------------------------------------------------
  logic signed [8:0]  left_error;     // raw error of previous pixel
  logic signed [11:0] pend_prev;      // sixteenths for lower-left
  logic signed [8:0]  pend_cur;       // sixteenths for lower-right

  logic signed [11:0] below;
  logic signed [8:0]  left_b;
  logic signed [11:0] pp_b;
  logic signed [8:0]  pc_b;
  logic signed [13:0] below_ext;
  logic signed [13:0] left_ext;
  logic signed [13:0] s_sum;
  logic signed [13:0] q_full;
  logic signed [9:0]  pix_ext;
  logic signed [9:0]  c_raw;
  logic [7:0]         c8;
  logic               dot_v;
  logic signed [8:0]  err;
  logic signed [12:0] err13;
  logic signed [12:0] err3;
  logic signed [12:0] err5;
  logic signed [12:0] pp13;
  logic signed [12:0] pc13;
  logic signed [12:0] below_cur;

  always_comb begin
    if (s1_zero) below = '0;
    else if (s1_fwd) below = s1_fwd_data;
    else below = mem_q;

    left_b = s1_fs ? '0 : left_error;
    pp_b   = s1_fs ? '0 : pend_prev;
    pc_b   = s1_fs ? '0 : pend_cur;

    below_ext = {{2{below[11]}}, below};
    left_ext  = {{5{left_b[8]}}, left_b};
    s_sum     = below_ext + (left_ext <<< 3) - left_ext;
    // round half up to whole gray levels
    q_full    = (s_sum + 14'sd8) >>> 4;
    pix_ext   = {2'b00, s1_pixel};
    c_raw     = pix_ext + q_full[9:0];

    if (c_raw < 10'sd0) c8 = 8'd0;
    else if (c_raw > 10'sd255) c8 = 8'd255;
    else c8 = c_raw[7:0];

    dot_v = c8 < threshold;
    err   = dot_v ? {1'b0, c8} : {1'b0, c8} - 9'sd255;

    err13 = {{4{err[8]}}, err};
    err3  = (err13 <<< 1) + err13;
    err5  = (err13 <<< 2) + err13;
    pp13  = {pp_b[11], pp_b};
    pc13  = {{4{pc_b[8]}}, pc_b};
    left_wr   = sat12(pp13 + err3);
    below_cur = pc13 + err5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_error <= '0;
      pend_prev  <= '0;
      pend_cur   <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        left_error <= '0;
        pend_prev  <= '0;
        pend_cur   <= '0;
      end else begin
        left_error <= err;
        pend_prev  <= below_cur[11:0];
        pend_cur   <= err;
      end
    end
  end

  // Deferred write of the row's last column; dropped when a new frame begins
  always_ff @(posedge clk) begin
    if (rst) pw_valid <= 1'b0;
    else if (in_acc && pix.data.frame_start) pw_valid <= 1'b0;
    else if (s1_adv && s1_last) pw_valid <= 1'b1;
    else if (!s1_wr) pw_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      pw_addr <= s1_col;
      pw_data <= sat12(below_cur);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  dot_t out_data;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s1_adv) out_valid <= 1'b1;
    else if (dots.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.dot     <= dot_v;
      out_data.row_end <= s1_last;
    end
  end

  assign dots.valid = out_valid;
  assign dots.data  = out_data;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The deferred write always finds the port free
  a_pw_no_clash: assert property (@(posedge clk) disable iff (rst)
    pw_valid |-> !s1_wr)
    else $error("deferred write collides with compute stage write");

  // Writes extend the written prefix by at most one entry
  a_fill_prefix: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (FW'(wr_addr) <= fill))
    else $error("line memory write leaves a gap in the fill prefix");

  // A frame start beat enters the compute stage at column zero
  a_fs_col0: assert property (@(posedge clk) disable iff (rst)
    (in_acc && pix.data.frame_start) |=> (s1_valid && s1_col == '0 && s1_zero))
    else $error("frame start not at column zero");

  // A row never ends at column zero
  a_row_end_col: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last) |-> (s1_col != '0))
    else $error("row end at column zero");

  // A last column write not dropped by a frame start becomes a deferred write
  a_pw_set: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last && !(in_acc && pix.data.frame_start)) |=> pw_valid)
    else $error("last column write not held");

endmodule
